/* rtl/pim_pkg.sv */
// shared types and constants for the pairwise identity matrix block
package pim_pkg;

    // field widths
    localparam int RES_W   = 3;
    localparam int IDX_W   = 3;
    localparam int COUNT_W = 17;
    localparam int SIM_W   = 17;
    localparam int CFG_W   = 4;
    localparam int FRAC_W  = 16;
    localparam int LANES   = 8;

    // saturation limit of a pair counter
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // reset value of the sequence count register
    localparam logic [CFG_W-1:0] SEQ_COUNT_RESET = 4'd8;

    // control from the sequencer to every pair lane
    typedef struct packed {
        logic count_en;
        logic clear;
    } t_lane_ctrl;

    // request into the identity divider
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] match_count;
        logic [COUNT_W-1:0] valid_count;
    } t_div_req;

    // status out of the identity divider
    typedef struct packed {
        logic             idle;
        logic             done;
        logic [SIM_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/pim_pair_lane.sv */
// one sequence pair: saturating valid and match counters
module pim_pair_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pim_pkg::t_lane_ctrl           i_ctrl,
    input  logic [pim_pkg::RES_W-1:0]     i_res_a,
    input  logic [pim_pkg::RES_W-1:0]     i_res_b,
    output logic [pim_pkg::COUNT_W-1:0]   o_valid_count,
    output logic [pim_pkg::COUNT_W-1:0]   o_match_count
);

    logic [pim_pkg::COUNT_W-1:0] r_valid_count, n_valid_count;
    logic [pim_pkg::COUNT_W-1:0] r_match_count, n_match_count;
    logic                        w_both_valid;
    logic                        w_equal;

    // position counts when both residues are present
    assign w_both_valid = (i_res_a != '0) && (i_res_b != '0);
    assign w_equal      = (i_res_a == i_res_b);

    // next counter values with saturation
    always_comb begin
        n_valid_count = r_valid_count;
        n_match_count = r_match_count;
        if (i_ctrl.clear) begin
            n_valid_count = '0;
            n_match_count = '0;
        end else if (i_ctrl.count_en && w_both_valid) begin
            if (r_valid_count != pim_pkg::COUNT_MAX) begin
                n_valid_count = r_valid_count + 1'b1;
            end
            if (w_equal && (r_match_count != pim_pkg::COUNT_MAX)) begin
                n_match_count = r_match_count + 1'b1;
            end
        end
    end

    // counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_count <= '0;
            r_match_count <= '0;
        end else begin
            r_valid_count <= n_valid_count;
            r_match_count <= n_match_count;
        end
    end

    assign o_valid_count = r_valid_count;
    assign o_match_count = r_match_count;

endmodule

/* rtl/pim_divider.sv */
// iterative divider: floor(match * 65536 / valid), one quotient bit per cycle
module pim_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pim_pkg::t_div_req i_req,
    input  logic              i_take,
    output pim_pkg::t_div_rsp o_rsp
);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_BUSY = 2'd1;
    localparam logic [1:0] DV_DONE = 2'd2;

    localparam int CNT_W = $clog2(pim_pkg::FRAC_W + 1);

    logic [1:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [pim_pkg::COUNT_W-1:0]   r_rem, n_rem;
    logic [pim_pkg::COUNT_W-1:0]   r_div, n_div;
    logic [pim_pkg::SIM_W-1:0]     r_quo, n_quo;
    logic [pim_pkg::COUNT_W:0]     w_shift;
    logic                          w_ge;
    logic [pim_pkg::COUNT_W:0]     w_diff;
    logic                          w_first_ge;

    // one restoring step on the doubled remainder
    assign w_shift    = {r_rem, 1'b0};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_diff     = w_shift - {1'b0, r_div};
    assign w_first_ge = (i_req.match_count >= i_req.valid_count);

    // sequencing of setup, sixteen steps and hold
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quo   = r_quo;
        unique case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    n_div = i_req.valid_count;
                    if (i_req.valid_count == '0) begin
                        n_quo   = '0;
                        n_state = DV_DONE;
                    end else begin
                        // integer bit of the fraction, match never exceeds valid
                        n_quo   = {{(pim_pkg::SIM_W-1){1'b0}}, w_first_ge};
                        n_rem   = w_first_ge ? (i_req.match_count - i_req.valid_count)
                                             : i_req.match_count;
                        n_cnt   = CNT_W'(pim_pkg::FRAC_W);
                        n_state = DV_BUSY;
                    end
                end
            end
            DV_BUSY: begin
                n_quo = {r_quo[pim_pkg::SIM_W-2:0], w_ge};
                n_rem = w_ge ? w_diff[pim_pkg::COUNT_W-1:0]
                             : w_shift[pim_pkg::COUNT_W-1:0];
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE: begin
                if (i_take) begin
                    n_state = DV_IDLE;
                end
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_rsp.idle     = (r_state == DV_IDLE);
    assign o_rsp.done     = (r_state == DV_DONE);
    assign o_rsp.quotient = r_quo;

endmodule

/* rtl/pairwise_identity_matrix_top.sv */
// Columns are taken one per cycle while o_stall is low; every pair lane counts in the same cycle.
// A last column starts a drain: each emitted pair passes through the
// bit-serial divider (setup, 16 steps, handoff); the output register holds one result.
// Input is stalled during the drain until the final pair enters the divider.
// Synchronous active-low reset clears all counters and sets the lane count to 8.
module pairwise_identity_matrix_top #(
    parameter int MAX_SEQUENCES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pim_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pim_pkg::RES_W-1:0]     i_residue_0,
    input  logic [pim_pkg::RES_W-1:0]     i_residue_1,
    input  logic [pim_pkg::RES_W-1:0]     i_residue_2,
    input  logic [pim_pkg::RES_W-1:0]     i_residue_3,
    input  logic [pim_pkg::RES_W-1:0]     i_residue_4,
    input  logic [pim_pkg::RES_W-1:0]     i_residue_5,
    input  logic [pim_pkg::RES_W-1:0]     i_residue_6,
    input  logic [pim_pkg::RES_W-1:0]     i_residue_7,
    input  logic                          i_last_column,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pim_pkg::IDX_W-1:0]     o_first_index,
    output logic [pim_pkg::IDX_W-1:0]     o_second_index,
    output logic [pim_pkg::SIM_W-1:0]     o_similarity,
    output logic                          o_last_pair
);

    localparam int PAIRS = (MAX_SEQUENCES * (MAX_SEQUENCES - 1)) / 2;
    localparam int SW    = $clog2(PAIRS + 1);
    localparam logic [pim_pkg::CFG_W-1:0] MAX_N = pim_pkg::CFG_W'(MAX_SEQUENCES);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                           r_state, n_state;
    logic [pim_pkg::CFG_W-1:0]      r_seq_count;
    logic [pim_pkg::IDX_W-1:0]      r_i, n_i;
    logic [pim_pkg::IDX_W-1:0]      r_j, n_j;
    logic [SW-1:0]                  r_slot, n_slot;
    logic [pim_pkg::IDX_W-1:0]      r_div_first, n_div_first;
    logic [pim_pkg::IDX_W-1:0]      r_div_second, n_div_second;
    logic                           r_div_last, n_div_last;
    logic                           r_out_valid;
    logic [pim_pkg::IDX_W-1:0]      r_out_first;
    logic [pim_pkg::IDX_W-1:0]      r_out_second;
    logic [pim_pkg::SIM_W-1:0]      r_out_sim;
    logic                           r_out_last;

    logic [pim_pkg::RES_W-1:0]      w_res [pim_pkg::LANES];
    logic [pim_pkg::COUNT_W-1:0]    w_valid_cnt [PAIRS];
    logic [pim_pkg::COUNT_W-1:0]    w_match_cnt [PAIRS];
    logic [pim_pkg::COUNT_W-1:0]    w_sel_valid;
    logic [pim_pkg::COUNT_W-1:0]    w_sel_match;
    logic [pim_pkg::CFG_W-1:0]      w_n_eff;
    logic                           w_accept;
    logic                           w_is_last_pair;
    logic                           w_row_wrap;
    logic                           w_take;
    pim_pkg::t_lane_ctrl            w_lane_ctrl;
    pim_pkg::t_div_req              w_div_req;
    pim_pkg::t_div_rsp              w_div_rsp;

    // residue lanes as an array
    assign w_res[0] = i_residue_0;
    assign w_res[1] = i_residue_1;
    assign w_res[2] = i_residue_2;
    assign w_res[3] = i_residue_3;
    assign w_res[4] = i_residue_4;
    assign w_res[5] = i_residue_5;
    assign w_res[6] = i_residue_6;
    assign w_res[7] = i_residue_7;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_count <= pim_pkg::SEQ_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_seq_count <= i_cfg_data;
        end
    end

    // lanes in use, clamped to the built lane count
    assign w_n_eff = (r_seq_count > MAX_N) ? MAX_N : r_seq_count;

    assign o_stall  = (r_state == ST_DRAIN);
    assign w_accept = i_valid && !o_stall;

    // one counter lane per pair, in upper-triangle order
    for (genvar gi = 0; gi < MAX_SEQUENCES; gi++) begin : g_row
        for (genvar gj = gi + 1; gj < MAX_SEQUENCES; gj++) begin : g_pair
            localparam int SLOT = (gi * (2 * MAX_SEQUENCES - gi - 1)) / 2 + (gj - gi - 1);
            pim_pair_lane u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_lane_ctrl),
                .i_res_a       (w_res[gi]),
                .i_res_b       (w_res[gj]),
                .o_valid_count (w_valid_cnt[SLOT]),
                .o_match_count (w_match_cnt[SLOT])
            );
        end
    end

    // merge: pick the counters of the pair being drained
    always_comb begin
        w_sel_valid = '0;
        w_sel_match = '0;
        for (int k = 0; k < PAIRS; k++) begin
            if (r_slot == SW'(k)) begin
                w_sel_valid = w_valid_cnt[k];
                w_sel_match = w_match_cnt[k];
            end
        end
    end

    // pair walk position
    assign w_is_last_pair = ({1'b0, r_i} == (w_n_eff - 4'd2)) &&
                            ({1'b0, r_j} == (w_n_eff - 4'd1));
    assign w_row_wrap     = (({1'b0, r_j} + 4'd1) >= w_n_eff);

    // drain sequencer
    always_comb begin
        n_state          = r_state;
        n_i              = r_i;
        n_j              = r_j;
        n_slot           = r_slot;
        n_div_first      = r_div_first;
        n_div_second     = r_div_second;
        n_div_last       = r_div_last;
        w_lane_ctrl      = '0;
        w_div_req.start  = 1'b0;
        w_div_req.match_count = w_sel_match;
        w_div_req.valid_count = w_sel_valid;
        w_lane_ctrl.count_en  = w_accept;
        unique case (r_state)
            ST_RUN: begin
                if (w_accept && i_last_column) begin
                    n_i     = '0;
                    n_j     = pim_pkg::IDX_W'(1);
                    n_slot  = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_n_eff < 4'd2) begin
                    // no pairs formed, only clear
                    w_lane_ctrl.clear = 1'b1;
                    n_state           = ST_RUN;
                end else if (w_div_rsp.idle) begin
                    w_div_req.start = 1'b1;
                    n_div_first     = r_i;
                    n_div_second    = r_j;
                    n_div_last      = w_is_last_pair;
                    if (w_is_last_pair) begin
                        w_lane_ctrl.clear = 1'b1;
                        n_state           = ST_RUN;
                    end else if (w_row_wrap) begin
                        n_i    = r_i + 1'b1;
                        n_j    = r_i + pim_pkg::IDX_W'(2);
                        n_slot = r_slot + SW'(MAX_SEQUENCES) - SW'(r_j);
                    end else begin
                        n_j    = r_j + 1'b1;
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_i     <= '0;
            r_j     <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_slot  <= n_slot;
        end
    end

    // pair tags that travel with the divider
    always_ff @(posedge i_clk) begin
        r_div_first  <= n_div_first;
        r_div_second <= n_div_second;
        r_div_last   <= n_div_last;
    end

    // shared identity divider
    pim_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_take  (w_take),
        .o_rsp   (w_div_rsp)
    );

    // output register, loads when empty or being drained
    assign w_take = w_div_rsp.done && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_first  <= r_div_first;
            r_out_second <= r_div_second;
            r_out_sim    <= w_div_rsp.quotient;
            r_out_last   <= r_div_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_first_index  = r_out_first;
    assign o_second_index = r_out_second;
    assign o_similarity   = r_out_sim;
    assign o_last_pair    = r_out_last;

endmodule
